@@ sv/vkf_pkg.sv @@
// Package for the velocity Kalman filter step: constants, types and helpers.
// No dependencies.
`timescale 1ns / 1ps
package vkf_pkg;

	localparam int FracBitsDefault = 16;
	localparam int DataW = 32;
	localparam int RegW = 31;
	localparam int RegIdxW = 2;
	localparam logic signed [DataW-1:0] MaxVal = 32'sh7FFF_FFFF;
	localparam logic signed [DataW-1:0] MinVal = 32'sh8000_0000;

	typedef enum logic [RegIdxW-1:0] {
		REG_TIME_STEP = 2'd0,
		REG_NOISE_POS = 2'd1,
		REG_NOISE_VEL = 2'd2,
		REG_NOISE_MEAS = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_DIV = 2'd1
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_M_XP0, ST_W_XP0,
		ST_M_P12, ST_W_P12,
		ST_M_P11A, ST_W_P11A,
		ST_M_P11B, ST_W_P11B,
		ST_D_K1, ST_W_K1,
		ST_D_K2, ST_W_K2,
		ST_M_X0, ST_W_X0,
		ST_M_X1, ST_W_X1,
		ST_M_C11, ST_W_C11,
		ST_M_C12, ST_W_C12,
		ST_M_C22, ST_W_C22,
		ST_OUT
	} state_t;

	// Handshake between the sequencer and the shared serial arithmetic unit.
	typedef struct packed {
		logic start;
		op_t op;
	} au_ctrl_t;

	// The two top bits of the widened sum differ only when the result left the range.
	function automatic logic signed [DataW-1:0] sat_add(
		input logic signed [DataW-1:0] a,
		input logic signed [DataW-1:0] b
	);
		logic signed [DataW:0] s;
		s = {a[DataW-1], a} + {b[DataW-1], b};
		if (s[DataW] != s[DataW-1]) begin
			return s[DataW] ? MinVal : MaxVal;
		end
		return s[DataW-1:0];
	endfunction

	function automatic logic signed [DataW-1:0] sat_sub(
		input logic signed [DataW-1:0] a,
		input logic signed [DataW-1:0] b
	);
		logic signed [DataW:0] s;
		s = {a[DataW-1], a} - {b[DataW-1], b};
		if (s[DataW] != s[DataW-1]) begin
			return s[DataW] ? MinVal : MaxVal;
		end
		return s[DataW-1:0];
	endfunction

endpackage

@@ sv/vkf_arith.sv @@
// Shared bit-serial multiplier and restoring divider on magnitudes.
// Depends on vkf_pkg.
`timescale 1ns / 1ps
module vkf_arith #(
	parameter int FRAC_BITS = vkf_pkg::FracBitsDefault
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  vkf_pkg::au_ctrl_t               ctrl,
	input  logic signed [vkf_pkg::DataW-1:0] a,
	input  logic signed [vkf_pkg::DataW-1:0] b,
	output logic                            done,
	output logic signed [vkf_pkg::DataW-1:0] result
);
	import vkf_pkg::*;

	// Product magnitude is at most 2^62; numerator (|a| << FRAC_BITS) is under 2^(32+FRAC_BITS).
	localparam int AccW = 2 * DataW;
	localparam int NumW = DataW + FRAC_BITS;
	localparam int CntW = $clog2(NumW + 1);
	localparam int MulSteps = DataW;

	logic [AccW-1:0] acc_q;    // product accumulator or remainder
	logic [AccW-1:0] mcand_q;  // shifted multiplicand
	logic [NumW-1:0] sh_q;     // multiplier bits or numerator bits, shifted out
	logic [NumW-1:0] quo_q;
	logic [DataW:0]  den_q;
	logic            neg_q;
	logic            busy_q;
	logic            div_q;
	logic            zero_q;
	logic [CntW-1:0] cnt_q;
	logic            done_q;
	logic signed [DataW-1:0] res_q;

	logic [DataW:0] mag_a, mag_b;
	assign mag_a = a[DataW-1] ? (DataW+1)'(-{a[DataW-1], a}) : {1'b0, a};
	assign mag_b = b[DataW-1] ? (DataW+1)'(-{b[DataW-1], b}) : {1'b0, b};

	logic [AccW:0] rem_try;
	logic [AccW-1:0] rem_sh;
	assign rem_sh = {acc_q[AccW-2:0], sh_q[NumW-1]};
	assign rem_try = {1'b0, rem_sh} - {{(AccW-DataW){1'b0}}, den_q};

	logic [AccW-1:0] mul_round;
	logic [AccW-1:0] mul_mag;
	assign mul_round = acc_q + (AccW'(1) << (FRAC_BITS - 1));
	assign mul_mag = mul_round >> FRAC_BITS;

	// Division rounding: compare twice the remainder with the divisor.
	logic [AccW:0] rem2;
	logic [NumW:0] quo_rnd;
	assign rem2 = {acc_q, 1'b0};
	assign quo_rnd = {1'b0, quo_q} + ((rem2 >= {{(AccW-DataW){1'b0}}, den_q}) ? 1'b1 : 1'b0);

	logic [AccW:0] fin_mag;
	assign fin_mag = div_q ? (AccW+1)'(quo_rnd) : {1'b0, mul_mag};

	logic signed [DataW-1:0] fin_val;
	always_comb begin
		if (neg_q) begin
			fin_val = (fin_mag > ((AccW+1)'(1) << (DataW-1))) ? MinVal
				: DataW'(-fin_mag[DataW-1:0]);
		end else begin
			fin_val = (fin_mag > (AccW+1)'(MaxVal)) ? MaxVal : fin_mag[DataW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			div_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start && !busy_q) begin
				busy_q <= 1'b1;
				div_q <= (ctrl.op == OP_DIV);
				cnt_q <= (ctrl.op == OP_DIV) ? CntW'(NumW) : CntW'(MulSteps);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start && !busy_q) begin
			acc_q <= '0;
			quo_q <= '0;
			neg_q <= a[DataW-1] ^ b[DataW-1];
			zero_q <= (b == '0);
			den_q <= mag_b;
			if (ctrl.op == OP_DIV) begin
				sh_q <= NumW'(mag_a) << FRAC_BITS;
				mcand_q <= '0;
			end else begin
				sh_q <= NumW'(mag_b);
				mcand_q <= AccW'(mag_a);
			end
		end else if (busy_q && cnt_q != '0) begin
			if (div_q) begin
				sh_q <= sh_q << 1;
				if (!rem_try[AccW]) begin
					acc_q <= rem_try[AccW-1:0];
					quo_q <= {quo_q[NumW-2:0], 1'b1};
				end else begin
					acc_q <= rem_sh;
					quo_q <= {quo_q[NumW-2:0], 1'b0};
				end
			end else begin
				if (sh_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				sh_q <= sh_q >> 1;
				mcand_q <= mcand_q << 1;
			end
		end else if (busy_q) begin
			res_q <= (div_q && zero_q) ? '0 : fin_val;
		end
	end

	assign done = done_q;
	assign result = res_q;
endmodule

@@ sv/velocity_kalman_filter_step.sv @@
// Two-state constant-velocity Kalman filter step with a velocity measurement.
// Each item runs eleven operations on one shared bit-serial unit that handles one
// multiplier bit or one quotient bit per cycle: nine multiplies and two divides.
// The result is held in an output register so a new item may start while it
// waits; a step only stalls at its end while the previous result is still
// undelivered. Depends on vkf_pkg, vkf_arith.
`timescale 1ns / 1ps
module velocity_kalman_filter_step #(
	parameter int FRAC_BITS = vkf_pkg::FracBitsDefault
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [vkf_pkg::RegIdxW-1:0]       cfg_index,
	input  logic [vkf_pkg::RegW-1:0]          cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [vkf_pkg::DataW-1:0]  measured_velocity,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [vkf_pkg::DataW-1:0]  position_estimate,
	output logic signed [vkf_pkg::DataW-1:0]  velocity_estimate,
	output logic signed [vkf_pkg::DataW-1:0]  cov_position,
	output logic signed [vkf_pkg::DataW-1:0]  cov_cross,
	output logic signed [vkf_pkg::DataW-1:0]  cov_velocity,
	output logic signed [vkf_pkg::DataW-1:0]  gain_position,
	output logic signed [vkf_pkg::DataW-1:0]  gain_velocity
);
	import vkf_pkg::*;

	localparam logic [RegW-1:0] DtReset = RegW'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic [RegW-1:0] QpReset = RegW'(64'd1 << FRAC_BITS);
	localparam logic [RegW-1:0] QvReset =
		(FRAC_BITS >= 30) ? {RegW{1'b1}} : RegW'(64'd3 << FRAC_BITS);
	localparam logic [RegW-1:0] RReset =
		(FRAC_BITS >= 28) ? {RegW{1'b1}} : RegW'(64'd10 << FRAC_BITS);
	localparam logic signed [DataW-1:0] VelReset =
		(FRAC_BITS >= 27) ? MaxVal : DataW'(64'd20 << FRAC_BITS);
	localparam logic signed [DataW-1:0] CovReset =
		(FRAC_BITS >= 29) ? MaxVal : DataW'(64'd5 << FRAC_BITS);

	logic [RegW-1:0] dt_q, qp_q, qv_q, r_q;
	logic signed [DataW-1:0] x0_q, x1_q, p11_q, p12_q, p22_q;
	logic signed [DataW-1:0] z_q, xp0_q, pp11_q, pp12_q, pp22_q, s_q, y_q, k1_q, k2_q;
	logic signed [DataW-1:0] tmp_q;
	logic signed [DataW-1:0] pos_out_q, vel_out_q, p11_out_q, p12_out_q, p22_out_q;
	logic signed [DataW-1:0] k1_out_q, k2_out_q;
	logic out_valid_q;
	logic out_load;
	state_t state_q, state_d;

	au_ctrl_t ctrl;
	logic signed [DataW-1:0] op_a, op_b, au_res;
	logic au_done;

	vkf_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .a(op_a), .b(op_b),
		.done(au_done), .result(au_res)
	);

	logic signed [DataW-1:0] dt_s;
	assign dt_s = {1'b0, dt_q};

	// The finished step moves into the output register once that register is free.
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= DtReset;
			qp_q <= QpReset;
			qv_q <= QvReset;
			r_q <= RReset;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TIME_STEP: dt_q <= cfg_data;
				REG_NOISE_POS: qp_q <= cfg_data;
				REG_NOISE_VEL: qv_q <= cfg_data;
				REG_NOISE_MEAS: r_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			x0_q <= '0;
			x1_q <= VelReset;
			p11_q <= CovReset;
			p12_q <= '0;
			p22_q <= CovReset;
			pos_out_q <= '0;
			vel_out_q <= '0;
			p11_out_q <= '0;
			p12_out_q <= '0;
			p22_out_q <= '0;
			k1_out_q <= '0;
			k2_out_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
				pos_out_q <= x0_q;
				vel_out_q <= x1_q;
				p11_out_q <= p11_q;
				p12_out_q <= p12_q;
				p22_out_q <= p22_q;
				k1_out_q <= k1_q;
				k2_out_q <= k2_q;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (au_done) begin
				unique case (state_q)
					ST_W_X0: x0_q <= sat_add(xp0_q, au_res);
					ST_W_X1: x1_q <= sat_add(x1_q, au_res);
					ST_W_C11: p11_q <= sat_sub(pp11_q, au_res);
					ST_W_C12: p12_q <= sat_sub(pp12_q, au_res);
					ST_W_C22: p22_q <= sat_sub(pp22_q, au_res);
					default: ;
				endcase
			end
		end
	end

	// Intermediate values of the step; no reset needed.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && in_ready) begin
			z_q <= measured_velocity;
			pp22_q <= sat_add(p22_q, {1'b0, qv_q});
		end
		if (state_q == ST_M_XP0) begin
			s_q <= sat_add(pp22_q, {1'b0, r_q});
			y_q <= sat_sub(z_q, x1_q);
		end
		if (au_done) begin
			unique case (state_q)
				ST_W_XP0: xp0_q <= sat_add(x0_q, au_res);
				ST_W_P12: pp12_q <= sat_add(p12_q, au_res);
				ST_W_P11A: tmp_q <= sat_add(p11_q, au_res);
				ST_W_P11B: pp11_q <= sat_add(sat_add(tmp_q, au_res), {1'b0, qp_q});
				ST_W_K1: k1_q <= au_res;
				ST_W_K2: k2_q <= au_res;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		ctrl.start = 1'b0;
		ctrl.op = OP_MUL;
		op_a = dt_s;
		op_b = x1_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_M_XP0;
			ST_M_XP0: begin ctrl.start = 1'b1; state_d = ST_W_XP0; end
			ST_W_XP0: if (au_done) state_d = ST_M_P12;
			ST_M_P12: begin
				ctrl.start = 1'b1; op_b = p22_q; state_d = ST_W_P12;
			end
			ST_W_P12: if (au_done) state_d = ST_M_P11A;
			ST_M_P11A: begin
				ctrl.start = 1'b1; op_b = p12_q; state_d = ST_W_P11A;
			end
			ST_W_P11A: if (au_done) state_d = ST_M_P11B;
			ST_M_P11B: begin
				ctrl.start = 1'b1; op_b = pp12_q; state_d = ST_W_P11B;
			end
			ST_W_P11B: if (au_done) state_d = ST_D_K1;
			ST_D_K1: begin
				ctrl.start = 1'b1; ctrl.op = OP_DIV;
				op_a = pp12_q; op_b = s_q; state_d = ST_W_K1;
			end
			ST_W_K1: if (au_done) state_d = ST_D_K2;
			ST_D_K2: begin
				ctrl.start = 1'b1; ctrl.op = OP_DIV;
				op_a = pp22_q; op_b = s_q; state_d = ST_W_K2;
			end
			ST_W_K2: if (au_done) state_d = ST_M_X0;
			ST_M_X0: begin
				ctrl.start = 1'b1; op_a = k1_q; op_b = y_q; state_d = ST_W_X0;
			end
			ST_W_X0: if (au_done) state_d = ST_M_X1;
			ST_M_X1: begin
				ctrl.start = 1'b1; op_a = k2_q; op_b = y_q; state_d = ST_W_X1;
			end
			ST_W_X1: if (au_done) state_d = ST_M_C11;
			ST_M_C11: begin
				ctrl.start = 1'b1; op_a = k1_q; op_b = pp12_q; state_d = ST_W_C11;
			end
			ST_W_C11: if (au_done) state_d = ST_M_C12;
			ST_M_C12: begin
				ctrl.start = 1'b1; op_a = k1_q; op_b = pp22_q; state_d = ST_W_C12;
			end
			ST_W_C12: if (au_done) state_d = ST_M_C22;
			ST_M_C22: begin
				ctrl.start = 1'b1; op_a = k2_q; op_b = pp22_q; state_d = ST_W_C22;
			end
			ST_W_C22: if (au_done) state_d = ST_OUT;
			ST_OUT: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign position_estimate = pos_out_q;
	assign velocity_estimate = vel_out_q;
	assign cov_position = p11_out_q;
	assign cov_cross = p12_out_q;
	assign cov_velocity = p22_out_q;
	assign gain_position = k1_out_q;
	assign gain_velocity = k2_out_q;
endmodule

@@ sv/vkf_checker.sv @@
// Port-level checker for the velocity Kalman filter step, with its bind.
// Depends on vkf_pkg and velocity_kalman_filter_step.
`timescale 1ns / 1ps
module vkf_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [vkf_pkg::DataW-1:0] position_estimate,
	input logic signed [vkf_pkg::DataW-1:0] cov_velocity
);
	import vkf_pkg::*;

	// An accepted item does not bring a new result in the next cycle.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid)) else $error("result too early");

	// A stalled result stays valid and holds its position estimate and velocity covariance.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(position_estimate)
		&& $stable(cov_velocity)) else $error("stalled result changed");

	// One item at a time: ready drops right after an item is accepted.
	a_ready_after: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("ready stayed high");
endmodule

bind velocity_kalman_filter_step vkf_checker u_vkf_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready),
	.position_estimate(position_estimate), .cov_velocity(cov_velocity)
);
